### rtl/hcle_pkg.sv
// ----------------------------------------------------------------------------
// hcle_pkg
// shared types and constants for the http content-length extractor
// ----------------------------------------------------------------------------
package hcle_pkg;

  localparam int unsigned LenW    = 40;
  localparam int unsigned NameLen = 14;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StNotFound = 2'd1,
    StBad      = 2'd2
  } status_e;

  typedef struct packed {
    logic               have;
    status_e            status;
    logic [LenW-1:0]    length;
  } result_t;

  // lower-case header name, one character per index
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h6c; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= ChUpA && b <= ChUpZ) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

### rtl/hcle_parser.sv
// ----------------------------------------------------------------------------
// hcle_parser
// per-message parse state; takes one byte per step and gives the result
// that byte causes
// ----------------------------------------------------------------------------
module hcle_parser #(
  parameter int unsigned VALUE_WIDTH = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output hcle_pkg::result_t  result_o
);

  localparam int unsigned CopyW = (VALUE_WIDTH < hcle_pkg::LenW) ? VALUE_WIDTH
                                                                  : hcle_pkg::LenW;

  typedef enum logic [2:0] {
    PhStatus = 3'd0,
    PhName   = 3'd1,
    PhOther  = 3'd2,
    PhWs     = 3'd3,
    PhDigits = 3'd4,
    PhTail   = 3'd5,
    PhDone   = 3'd6
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   cr_q, cr_d;
  logic                   line_start_q, line_start_d;
  logic [3:0]             name_cnt_q, name_cnt_d;
  logic                   name_ok_q, name_ok_d;
  logic                   neg_q, neg_d;
  logic                   digit_q, digit_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;

  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [VALUE_WIDTH+3:0] acc_times10;
  logic [VALUE_WIDTH-1:0] acc_next;
  hcle_pkg::result_t      res;

  assign is_digit  = (data_byte_i >= hcle_pkg::ChZero) && (data_byte_i <= hcle_pkg::ChNine);
  assign digit_val = data_byte_i[3:0];

  // acc * 10 + d, saturating at the value width
  always_comb begin
    acc_times10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                + {{VALUE_WIDTH{1'b0}}, digit_val};
    if (acc_times10[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0) begin
      acc_next = '1;
    end else begin
      acc_next = acc_times10[VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    phase_d      = phase_q;
    cr_d         = cr_q;
    line_start_d = line_start_q;
    name_cnt_d   = name_cnt_q;
    name_ok_d    = name_ok_q;
    neg_d        = neg_q;
    digit_d      = digit_q;
    acc_d        = acc_q;
    res          = '0;
    res.status   = hcle_pkg::StFound;

    if (phase_q != PhDone) begin
      if (cr_q && data_byte_i == hcle_pkg::ChLf) begin
        cr_d = 1'b0;
        if (phase_q == PhStatus ||
            ((phase_q == PhName || phase_q == PhOther) && !line_start_q)) begin
          // new header line
          phase_d      = PhName;
          line_start_d = 1'b1;
          name_cnt_d   = '0;
          name_ok_d    = 1'b1;
          neg_d        = 1'b0;
          digit_d      = 1'b0;
          acc_d        = '0;
        end else if (phase_q == PhName || phase_q == PhOther) begin
          // empty line ends the header block
          res.have   = 1'b1;
          res.status = hcle_pkg::StNotFound;
          phase_d    = PhDone;
        end else begin
          res.have = 1'b1;
          phase_d  = PhDone;
          if (!digit_q || (neg_q && acc_q != '0)) begin
            res.status = hcle_pkg::StBad;
          end else begin
            res.status              = hcle_pkg::StFound;
            res.length[CopyW-1:0]   = acc_q[CopyW-1:0];
          end
        end
      end else begin
        if (cr_q || data_byte_i != hcle_pkg::ChCr) begin
          line_start_d = 1'b0;
        end
        cr_d = (data_byte_i == hcle_pkg::ChCr);
        unique case (phase_q)
          PhName: begin
            if (data_byte_i == hcle_pkg::ChColon) begin
              if (name_ok_q && name_cnt_q == 4'(hcle_pkg::NameLen)) begin
                phase_d = PhWs;
                neg_d   = 1'b0;
                digit_d = 1'b0;
                acc_d   = '0;
              end else begin
                phase_d = PhOther;
              end
            end else begin
              if (name_cnt_q >= 4'(hcle_pkg::NameLen) ||
                  hcle_pkg::to_lower(data_byte_i) != hcle_pkg::name_char(name_cnt_q)) begin
                name_ok_d = 1'b0;
              end
              if (name_cnt_q != 4'd15) begin
                name_cnt_d = name_cnt_q + 4'd1;
              end
            end
          end
          PhWs: begin
            if (data_byte_i == hcle_pkg::ChSpace || data_byte_i == hcle_pkg::ChTab) begin
              phase_d = PhWs;
            end else if (data_byte_i == hcle_pkg::ChPlus ||
                         data_byte_i == hcle_pkg::ChMinus) begin
              neg_d   = (data_byte_i == hcle_pkg::ChMinus);
              phase_d = PhDigits;
            end else if (is_digit) begin
              digit_d = 1'b1;
              acc_d   = acc_next;
              phase_d = PhDigits;
            end else begin
              phase_d = PhTail;
            end
          end
          PhDigits: begin
            if (is_digit) begin
              digit_d = 1'b1;
              acc_d   = acc_next;
            end else begin
              phase_d = PhTail;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    if (last_byte_i) begin
      if (!res.have && phase_q != PhDone) begin
        res.have   = 1'b1;
        res.status = hcle_pkg::StNotFound;
        res.length = '0;
      end
      // back to reset values for the next message
      phase_d      = PhStatus;
      cr_d         = 1'b0;
      line_start_d = 1'b0;
      name_cnt_d   = '0;
      name_ok_d    = 1'b1;
      neg_d        = 1'b0;
      digit_d      = 1'b0;
      acc_d        = '0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStatus;
      cr_q         <= 1'b0;
      line_start_q <= 1'b0;
      name_cnt_q   <= '0;
      name_ok_q    <= 1'b1;
      neg_q        <= 1'b0;
      digit_q      <= 1'b0;
      acc_q        <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      cr_q         <= cr_d;
      line_start_q <= line_start_d;
      name_cnt_q   <= name_cnt_d;
      name_ok_q    <= name_ok_d;
      neg_q        <= neg_d;
      digit_q      <= digit_d;
      acc_q        <= acc_d;
    end
  end

endmodule

### rtl/http_content_length_extractor_top.sv
// ----------------------------------------------------------------------------
// http_content_length_extractor_top
// finds the content-length header of an http response, one byte per cycle
// ----------------------------------------------------------------------------
// Bytes enter an input register and are parsed one per cycle unless an
// unaccepted result holds the output register; a header result is
// registered there as its byte is parsed, which raises out_valid_o.
// The sustained rate is one byte per cycle while results drain, set by the
// parse-state update (name compare or one decimal multiply-add step).
// A message gives at most one result: found with the length, bad_value,
// or not_found on an empty header line or at the last byte. The value
// saturates at VALUE_WIDTH bits; length_o carries its low 40 bits.
module http_content_length_extractor_top #(
  parameter int unsigned VALUE_WIDTH = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [hcle_pkg::LenW-1:0]   length_o
);

  logic                      in_vld_q;
  logic [7:0]                byte_q;
  logic                      last_q;
  logic                      step;
  hcle_pkg::result_t         res;
  logic                      out_vld_q;
  logic [1:0]                status_q;
  logic [hcle_pkg::LenW-1:0] length_q;

  // parse a held byte once the result slot is free or draining
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  hcle_parser #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= res.have;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.have) begin
      status_q <= res.status;
      length_q <= res.length;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign length_o    = length_q;

endmodule
